// File: rtl/core/sidu_pkg.sv
// shared constants and controller/datapath signal types for the signed divider
`timescale 1ns / 1ps

package sidu_pkg;

   localparam int DEF_DATA_WIDTH = 32;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture operands, form magnitudes and signs
      logic step;     // one restoring shift and subtract
      logic finish;   // apply sign, saturate, register the result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic zero_div;  // captured divisor was zero
   } stat_type;

endpackage

// File: rtl/core/sidu_if.sv
// valid/ready channel interfaces for divider requests and responses
`timescale 1ns / 1ps

interface sidu_req_if #(
   parameter int WIDTH = 32
) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] numerator;
   logic signed [WIDTH-1:0] denominator;

   modport source (output valid, output numerator, output denominator, input ready);
   modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface sidu_rsp_if #(
   parameter int WIDTH = 32
) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] quotient;
   logic                    overflow;
   logic                    div_by_zero;

   modport source (output valid, output quotient, output overflow, output div_by_zero,
                   input ready);
   modport sink   (input valid, input quotient, input overflow, input div_by_zero,
                   output ready);
endinterface

// File: rtl/core/sidu_datapath.sv
// divider datapath: operand magnitudes, restoring remainder/quotient shifter, sign fix-up
`timescale 1ns / 1ps

module sidu_datapath #(
   parameter int DATA_WIDTH = sidu_pkg::DEF_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sidu_pkg::cmd_type            cmd,
   output sidu_pkg::stat_type           stat,
   input  logic signed [DATA_WIDTH-1:0] numerator,
   input  logic signed [DATA_WIDTH-1:0] denominator,
   output logic signed [DATA_WIDTH-1:0] quotient,
   output logic                         overflow,
   output logic                         div_by_zero
);
   import sidu_pkg::*;

   localparam int DW = DATA_WIDTH;

   // numerator bits shift out of the top while quotient bits shift in at the bottom
   logic [DW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic          zero_ff, zero_in;
   logic [DW-1:0] quot_ff, quot_in;
   logic          ovf_ff, ovf_in;
   logic          dz_ff, dz_in;

   logic [DW:0]   rem_shift;
   logic [DW:0]   diff;

   always_comb begin
      rem_shift = {rem_ff, num_ff[DW-1]};
      diff      = rem_shift - {1'b0, den_ff};

      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      dz_in   = dz_ff;

      if (cmd.load) begin
         num_in  = numerator[DW-1] ? (~numerator + 1'b1) : numerator;
         den_in  = denominator[DW-1] ? (~denominator + 1'b1) : denominator;
         rem_in  = '0;
         neg_in  = numerator[DW-1] ^ denominator[DW-1];
         zero_in = (denominator == '0);
      end else if (cmd.step) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            num_in = {num_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DW-1:0];
            num_in = {num_ff[DW-2:0], 1'b0};
         end
      end

      if (cmd.finish) begin
         ovf_in = 1'b0;
         dz_in  = 1'b0;
         if (zero_ff) begin
            quot_in = '0;
            dz_in   = 1'b1;
         end else if (neg_ff) begin
            quot_in = ~num_ff + 1'b1;
         end else if (num_ff[DW-1]) begin
            // only the most negative value over minus one lands here
            quot_in = {1'b0, {(DW-1){1'b1}}};
            ovf_in  = 1'b1;
         end else begin
            quot_in = num_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff <= 1'b0;
      end else begin
         zero_ff <= zero_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      dz_ff   <= dz_in;
   end

   assign stat.zero_div = zero_ff;
   assign quotient      = quot_ff;
   assign overflow      = ovf_ff;
   assign div_by_zero   = dz_ff;

endmodule

// File: rtl/core/sidu_controller.sv
// divider controller: handshakes, iteration counter and datapath sequencing
`timescale 1ns / 1ps

module sidu_controller #(
   parameter int DATA_WIDTH = sidu_pkg::DEF_DATA_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sidu_pkg::cmd_type  cmd,
   input  sidu_pkg::stat_type stat
);
   import sidu_pkg::*;

   localparam int CW = $clog2(DATA_WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] count_ff;
   logic          req_ready_ff;
   logic          rsp_valid_ff;
   logic          accept;

   assign accept = req_valid && req_ready_ff;

   always_comb begin
      cmd.load   = accept;
      cmd.step   = (state_ff == ST_DIVIDE) && !stat.zero_div;
      cmd.finish = (state_ff == ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               req_ready_ff <= 1'b1;
               if (accept) begin
                  req_ready_ff <= 1'b0;
                  count_ff     <= CW'(DATA_WIDTH - 1);
                  state_ff     <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               // a zero divisor needs no iterations
               if (stat.zero_div || count_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  count_ff <= count_ff - 1'b1;
               end
            end
            ST_FINISH: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_RESPOND;
            end
            ST_RESPOND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/signed_integer_divider_unit.sv
// Signed integer divider, radix-2 restoring, one item in flight at a time.
// An item carries a two's complement numerator and denominator of DATA_WIDTH bits and
// returns the quotient truncated toward zero. The most negative value divided by minus
// one saturates to the largest positive value with overflow set; a zero denominator
// returns zero with div_by_zero set. From accept to the earliest response handshake an
// item passes the shift and subtract loop, one quotient bit per cycle, then the sign
// fix-up state and the response state; a zero denominator skips the loop. The next item
// is accepted the cycle after the response is taken.
`timescale 1ns / 1ps

module signed_integer_divider_unit #(
   parameter int DATA_WIDTH = sidu_pkg::DEF_DATA_WIDTH
) (
   input logic        clock,
   input logic        reset,
   sidu_req_if.sink   req_ch,
   sidu_rsp_if.source rsp_ch
);
   import sidu_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sidu_controller #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   sidu_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .numerator   (req_ch.numerator),
      .denominator (req_ch.denominator),
      .quotient    (rsp_ch.quotient),
      .overflow    (rsp_ch.overflow),
      .div_by_zero (rsp_ch.div_by_zero)
   );

endmodule

// File: bench/testbench.sv
// self-checking testbench for the signed integer divider unit
`timescale 1ns / 1ps

module testbench;

   localparam int DW = sidu_pkg::DEF_DATA_WIDTH;
   localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW - 1){1'b0}}};
   localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW - 1){1'b1}}};
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = DW + 8;

   typedef struct packed {
      logic [DW-1:0] quotient;
      logic          overflow;
      logic          div_by_zero;
   } quotient_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sidu_req_if #(.WIDTH(DW)) req_ch ();
   sidu_rsp_if #(.WIDTH(DW)) rsp_ch ();

   signed_integer_divider_unit #(
      .DATA_WIDTH(DW)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   quotient_type pending_quotients[$];
   quotient_type expected_quotient;
   int           mismatch_count = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           quiet_cycles = 0;
   bit           offering = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // magnitudes divided unsigned, then the sign is applied
   function automatic quotient_type predict_quotient(input logic [DW-1:0] num,
                                                     input logic [DW-1:0] den);
      quotient_type  res;
      logic          num_neg;
      logic          den_neg;
      logic [DW-1:0] num_mag;
      logic [DW-1:0] den_mag;
      logic [DW-1:0] mag;
      res.quotient    = '0;
      res.overflow    = 1'b0;
      res.div_by_zero = 1'b0;
      num_neg = num[DW-1];
      den_neg = den[DW-1];
      num_mag = num_neg ? -num : num;
      den_mag = den_neg ? -den : den;
      if (den == '0) begin
         res.div_by_zero = 1'b1;
      end else begin
         mag = num_mag / den_mag;
         if (num_neg != den_neg) begin
            res.quotient = -mag;
         end else if (mag[DW-1]) begin
            res.quotient = MOST_POS;
            res.overflow = 1'b1;
         end else begin
            res.quotient = mag;
         end
      end
      return res;
   endfunction

   function automatic logic [DW-1:0] random_operand();
      logic [DW-1:0] v;
      int            shift;
      shift = $urandom_range(0, DW - 1);
      case ($urandom_range(0, 5))
         1: v = $urandom_range(0, 32) - 16;
         2: begin
            v = '0;
            v[shift] = 1'b1;
            if ($urandom_range(0, 1)) v = v - 1'b1;
            if ($urandom_range(0, 1)) v = -v;
         end
         3: begin
            case ($urandom_range(0, 4))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = '1;
               3: v = '0;
               default: v = 1;
            endcase
         end
         4: v = $signed($urandom) >>> shift;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // called at a rising edge, returns at the edge where the item is taken
   task automatic send_division(input logic [DW-1:0] num, input logic [DW-1:0] den);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         if (offering) req_ch.valid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.numerator   <= num;
      req_ch.denominator <= den;
      offering = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_quotients = {pending_quotients, predict_quotient(num, den)};
   endtask

   task automatic hold_until_drained();
      if (offering) begin
         req_ch.valid <= 1'b0;
         offering = 1'b0;
         @(posedge clock);
      end
      while (pending_quotients.size() != 0) @(posedge clock);
   endtask

   // truncation toward zero in every sign combination
   task automatic test_truncation_signs();
      send_division(7, 2);
      send_division(-7, 2);
      send_division(7, -2);
      send_division(-7, -2);
      send_division(1, MOST_POS);
      send_division(MOST_POS, 1);
      send_division(-1, -1);
   endtask

   task automatic test_zero_operands();
      send_division(0, 5);
      send_division(0, -1);
      send_division(0, MOST_NEG);
      send_division(5, 0);
      send_division(0, 0);
      send_division(MOST_NEG, 0);
      send_division('1, 0);
   endtask

   task automatic test_overflow_extremes();
      send_division(MOST_NEG, '1);
      send_division(MOST_NEG, 1);
      send_division(MOST_POS, '1);
      send_division(MOST_NEG, MOST_NEG);
      send_division(MOST_POS, MOST_POS);
      send_division(MOST_POS, MOST_NEG);
      send_division('1, MOST_NEG);
      send_division(MOST_NEG, MOST_POS);
   endtask

   task automatic test_random_division(input int count, input int send_pct,
                                       input int stall);
      send_idle_pct = send_pct;
      stall_pct     = stall;
      for (int i = 0; i < count; i++) begin
         send_division(random_operand(), random_operand());
      end
      hold_until_drained();
   endtask

   // result side: random backpressure and in-order compare
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_quotients.size() == 0) begin
            $error("result with no item outstanding: quotient %0d", $signed(rsp_ch.quotient));
            mismatch_count++;
         end else begin
            expected_quotient = pending_quotients.pop_front();
            if (rsp_ch.quotient !== expected_quotient.quotient) begin
               $error("quotient: expected %0d, actual %0d",
                      $signed(expected_quotient.quotient), $signed(rsp_ch.quotient));
               mismatch_count++;
            end
            if (rsp_ch.overflow !== expected_quotient.overflow) begin
               $error("overflow: expected %0b, actual %0b",
                      expected_quotient.overflow, rsp_ch.overflow);
               mismatch_count++;
            end
            if (rsp_ch.div_by_zero !== expected_quotient.div_by_zero) begin
               $error("div_by_zero: expected %0b, actual %0b",
                      expected_quotient.div_by_zero, rsp_ch.div_by_zero);
               mismatch_count++;
            end
         end
      end
   end

   // cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.numerator   <= '0;
      req_ch.denominator <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_truncation_signs();
      test_zero_operands();
      test_overflow_extremes();
      hold_until_drained();
      test_random_division(175, 0, 0);
      test_random_division(175, 79, 0);
      test_random_division(175, 0, 79);
      test_random_division(175, 14, 14);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_quotients.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/sidu_pkg.sv
rtl/core/sidu_if.sv
rtl/core/sidu_datapath.sv
rtl/core/sidu_controller.sv
rtl/core/signed_integer_divider_unit.sv
bench/testbench.sv
